// ----- rtl/lru_key_value_cache_core_assert.svh -----
// assertion macros used by the checker file
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, quiet during reset
`define LKVC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, quiet during reset
`define LKVC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/lkvc_pkg.sv -----
`default_nettype none

package lkvc_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_W   = 16;
    localparam int VAL_W   = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } t_state;

endpackage

`default_nettype wire

// ----- rtl/lru_key_value_cache_core.sv -----
// channel   | direction | handshake              | payload
// ----------+-----------+------------------------+---------------------------------------------
// request   | in        | start, busy            | i_mode, i_lookup_key, i_store_value
// response  | out       | o_valid (strobe)       | o_found, o_read_data, o_evicted, o_evicted_key
// config    | in        | i_cfg_we               | i_cfg_wdata (capacity in use)
//
// a beat is taken when start is high and busy is low; busy rises the next cycle
// each beat runs an accept cycle, then scan cycles in which the shared key
// comparator and rank compare visit one entry each, then a write-back cycle
// the response strobe o_valid is high for exactly one cycle, in the cycle after write-back
// the receiver cannot stall: the response is gone after its strobe cycle
// i_rst_n is synchronous, active low; it empties the store and sets capacity to 16
`default_nettype none

module lru_key_value_cache_core (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    // request
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_mode,
    input  wire logic [lkvc_pkg::KEY_W-1:0]  i_lookup_key,
    input  wire logic signed [lkvc_pkg::VAL_W-1:0] i_store_value,
    // configuration
    input  wire logic                        i_cfg_we,
    input  wire logic [lkvc_pkg::CAP_W-1:0]  i_cfg_wdata,
    // response
    output logic                             o_valid,
    output logic                             o_found,
    output logic signed [lkvc_pkg::VAL_W-1:0] o_read_data,
    output logic                             o_evicted,
    output logic [lkvc_pkg::KEY_W-1:0]       o_evicted_key
);

    localparam int ENTRIES = lkvc_pkg::ENTRIES;
    localparam int IDX_W   = lkvc_pkg::IDX_W;
    localparam int CNT_W   = lkvc_pkg::CNT_W;
    localparam int KEY_W   = lkvc_pkg::KEY_W;
    localparam int VAL_W   = lkvc_pkg::VAL_W;

    // sequencer
    lkvc_pkg::t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx;

    // configuration
    logic [lkvc_pkg::CAP_W-1:0] r_cap;

    // stored entries: key and value need no reset, valid and rank do
    logic [KEY_W-1:0] r_keys [ENTRIES];
    logic [VAL_W-1:0] r_vals [ENTRIES];
    logic [ENTRIES-1:0] r_valid, n_valid;
    logic [IDX_W-1:0] r_rank [ENTRIES];
    logic [IDX_W-1:0] n_rank [ENTRIES];
    logic [CNT_W-1:0] r_used, n_used;

    // latched request
    logic             r_mode;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_val;

    // scan results
    logic             r_hit;
    logic [IDX_W-1:0] r_hit_slot;
    logic [IDX_W-1:0] r_hit_rank;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_free_found;
    logic [IDX_W-1:0] r_free_slot;
    logic             r_lru_found;
    logic [IDX_W-1:0] r_lru_slot;
    logic [IDX_W-1:0] r_lru_rank;
    logic [KEY_W-1:0] r_lru_key;

    // shared compare unit: looks at the entry under r_idx
    logic             cur_valid;
    logic [KEY_W-1:0] cur_key;
    logic [IDX_W-1:0] cur_rank;
    logic             key_match;
    logic             lru_better;
    logic             scan_last;

    // write-back decision
    logic [31:0]      eff_cap;
    logic             has_room;
    logic             use_free;
    logic             do_insert;
    logic             do_evict;
    logic [IDX_W-1:0] ins_slot;

    assign cur_valid  = r_valid[r_idx];
    assign cur_key    = r_keys[r_idx];
    assign cur_rank   = r_rank[r_idx];
    assign key_match  = cur_valid && (cur_key == r_key);
    assign lru_better = cur_valid && (!r_lru_found || (cur_rank > r_lru_rank));
    assign scan_last  = (r_idx == IDX_W'(ENTRIES - 1));

    assign busy = (r_state != lkvc_pkg::ST_IDLE);

    // capacity zero counts as one, anything above the table size saturates
    always_comb begin
        if (r_cap == '0) begin
            eff_cap = 32'd1;
        end else if (32'(r_cap) > 32'(ENTRIES)) begin
            eff_cap = 32'(ENTRIES);
        end else begin
            eff_cap = 32'(r_cap);
        end
    end

    assign has_room  = (32'(r_used) < eff_cap);
    assign use_free  = has_room && r_free_found;
    assign do_insert = !r_hit && (r_mode == lkvc_pkg::MODE_PUT) && (use_free || r_lru_found);
    assign do_evict  = do_insert && !use_free;
    assign ins_slot  = use_free ? r_free_slot : r_lru_slot;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (start) n_state = lkvc_pkg::ST_SCAN;
            end
            lkvc_pkg::ST_SCAN: begin
                if (scan_last) n_state = lkvc_pkg::ST_DONE;
            end
            lkvc_pkg::ST_DONE: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
            default: begin
                n_state = lkvc_pkg::ST_IDLE;
            end
        endcase
    end

    // recency and occupancy update, applied in the write-back cycle
    always_comb begin
        n_valid = r_valid;
        n_used  = r_used;
        for (int j = 0; j < ENTRIES; j++) begin
            n_rank[j] = r_rank[j];
        end
        if (r_state == lkvc_pkg::ST_DONE) begin
            if (r_hit) begin
                // hit entry goes to the front, the ones ahead of it slide back one
                for (int j = 0; j < ENTRIES; j++) begin
                    if (IDX_W'(j) == r_hit_slot) begin
                        n_rank[j] = '0;
                    end else if (r_valid[j] && (r_rank[j] < r_hit_rank)) begin
                        n_rank[j] = r_rank[j] + 1'b1;
                    end
                end
            end else if (do_insert) begin
                // everyone ages, new entry is most recent
                for (int j = 0; j < ENTRIES; j++) begin
                    if (IDX_W'(j) == ins_slot) begin
                        n_rank[j]  = '0;
                        n_valid[j] = 1'b1;
                    end else if (r_valid[j]) begin
                        n_rank[j] = r_rank[j] + 1'b1;
                    end
                end
                if (!do_evict) n_used = r_used + 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lkvc_pkg::ST_IDLE;
            r_cap   <= lkvc_pkg::CAP_RESET;
            r_valid <= '0;
            r_used  <= '0;
            o_valid <= 1'b0;
            for (int j = 0; j < ENTRIES; j++) begin
                r_rank[j] <= '0;
            end
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_used  <= n_used;
            o_valid <= (r_state == lkvc_pkg::ST_DONE);
            for (int j = 0; j < ENTRIES; j++) begin
                r_rank[j] <= n_rank[j];
            end
            if (i_cfg_we) r_cap <= i_cfg_wdata;
        end
    end

    // request latch, scan tracking and response payload
    always_ff @(posedge i_clk) begin
        case (r_state)
            lkvc_pkg::ST_IDLE: begin
                if (start) begin
                    r_mode       <= i_mode;
                    r_key        <= i_lookup_key;
                    r_val        <= i_store_value;
                    r_idx        <= '0;
                    r_hit        <= 1'b0;
                    r_free_found <= 1'b0;
                    r_lru_found  <= 1'b0;
                end
            end
            lkvc_pkg::ST_SCAN: begin
                // first matching key wins
                if (key_match && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_slot <= r_idx;
                    r_hit_rank <= cur_rank;
                    r_hit_val  <= r_vals[r_idx];
                end
                // lowest empty slot
                if (!cur_valid && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_slot  <= r_idx;
                end
                // highest rank is the least recent
                if (lru_better) begin
                    r_lru_found <= 1'b1;
                    r_lru_slot  <= r_idx;
                    r_lru_rank  <= cur_rank;
                    r_lru_key   <= cur_key;
                end
                r_idx <= r_idx + 1'b1;
            end
            lkvc_pkg::ST_DONE: begin
                // entry payload write-back
                if (r_hit && (r_mode == lkvc_pkg::MODE_PUT)) begin
                    r_vals[r_hit_slot] <= r_val;
                end else if (do_insert) begin
                    r_keys[ins_slot] <= r_key;
                    r_vals[ins_slot] <= r_val;
                end
                o_found       <= r_hit;
                o_read_data   <= (r_hit && (r_mode == lkvc_pkg::MODE_GET)) ? r_hit_val : '1;
                o_evicted     <= do_evict;
                o_evicted_key <= do_evict ? r_lru_key : '0;
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/lkvc_checker.sv -----
`default_nettype none

`include "lru_key_value_cache_core_assert.svh"

module lkvc_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_valid,
    input wire logic                       o_found,
    input wire logic                       o_evicted,
    input wire logic [lkvc_pkg::KEY_W-1:0] o_evicted_key
);

    // an accepted beat makes the core busy
    `LKVC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")

    // a strobe lasts one cycle
    `LKVC_ASSERT_NEXT(a_strobe_single, o_valid, !o_valid, "response strobe held two cycles")

    // eviction only happens for a new key
    `LKVC_ASSERT_NOW(a_evict_miss, o_valid && o_evicted, !o_found, "eviction on a hit")

    // no eviction means a zero key
    `LKVC_ASSERT_NOW(a_evkey_zero, o_valid && !o_evicted, o_evicted_key == '0,
        "evicted key nonzero without eviction")

endmodule

bind lru_key_value_cache_core lkvc_checker u_lkvc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_valid       (o_valid),
    .o_found       (o_found),
    .o_evicted     (o_evicted),
    .o_evicted_key (o_evicted_key)
);

`default_nettype wire

// ----- verif/testbench.sv -----
`default_nettype none

module testbench;

    // one operation or one capacity write, in the order it is to be issued
    typedef struct {
        bit                                 is_cap_write;
        logic                               mode;
        logic [lkvc_pkg::KEY_W-1:0]         key;
        logic [lkvc_pkg::VAL_W-1:0]         value;
        logic [lkvc_pkg::CAP_W-1:0]         cap;
    } t_cache_op;

    // what one beat should return
    typedef struct packed {
        logic                               found;
        logic [lkvc_pkg::VAL_W-1:0]         read_data;
        logic                               evicted;
        logic [lkvc_pkg::KEY_W-1:0]         evicted_key;
    } t_lookup_answer;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PHASES       = 12;

    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    logic                               i_mode = lkvc_pkg::MODE_GET;
    logic [lkvc_pkg::KEY_W-1:0]         i_lookup_key = '0;
    logic signed [lkvc_pkg::VAL_W-1:0]  i_store_value = '0;
    logic                               i_cfg_we = 1'b0;
    logic [lkvc_pkg::CAP_W-1:0]         i_cfg_wdata = '0;
    logic                               o_valid;
    logic                               o_found;
    logic signed [lkvc_pkg::VAL_W-1:0]  o_read_data;
    logic                               o_evicted;
    logic [lkvc_pkg::KEY_W-1:0]         o_evicted_key;

    lru_key_value_cache_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_mode        (i_mode),
        .i_lookup_key  (i_lookup_key),
        .i_store_value (i_store_value),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_valid       (o_valid),
        .o_found       (o_found),
        .o_read_data   (o_read_data),
        .o_evicted     (o_evicted),
        .o_evicted_key (o_evicted_key)
    );

    // clock, period 4
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // shadow copy of the cache contents and recency order
    logic [lkvc_pkg::KEY_W-1:0] line_key   [lkvc_pkg::ENTRIES];
    logic [lkvc_pkg::VAL_W-1:0] line_value [lkvc_pkg::ENTRIES];
    bit                         line_valid [lkvc_pkg::ENTRIES];
    int                         line_rank  [lkvc_pkg::ENTRIES];
    int                         lines_used;
    logic [lkvc_pkg::CAP_W-1:0] cap_reg;

    t_cache_op      op_queue[$];
    t_lookup_answer pending_lookups[$];

    int beats_sent;     // driver side, blocking
    int results_seen;   // monitor side, nonblocking
    int mismatches;
    int cycle_count;

    // capacity as the block uses it: zero means one, above ENTRIES saturates
    function automatic int cap_limit();
        int c;
        c = int'(cap_reg);
        if (c == 0) c = 1;
        if (c > lkvc_pkg::ENTRIES) c = lkvc_pkg::ENTRIES;
        return c;
    endfunction

    // apply one operation to the shadow cache and return its answer
    function automatic t_lookup_answer cache_access(
        input logic                       mode,
        input logic [lkvc_pkg::KEY_W-1:0] key,
        input logic [lkvc_pkg::VAL_W-1:0] value
    );
        t_lookup_answer ans;
        int hit;
        int slot;
        int old_rank;
        ans.found       = 1'b0;
        ans.read_data   = '1;
        ans.evicted     = 1'b0;
        ans.evicted_key = '0;
        hit = -1;
        for (int j = 0; j < lkvc_pkg::ENTRIES; j++)
            if (hit < 0 && line_valid[j] && line_key[j] == key) hit = j;
        if (hit >= 0) begin
            ans.found = 1'b1;
            if (mode == lkvc_pkg::MODE_GET) ans.read_data = line_value[hit];
            else line_value[hit] = value;
            // entries more recent than the hit slide down one rank
            old_rank = line_rank[hit];
            for (int j = 0; j < lkvc_pkg::ENTRIES; j++)
                if (line_valid[j] && j != hit && line_rank[j] < old_rank) line_rank[j]++;
            line_rank[hit] = 0;
        end else if (mode == lkvc_pkg::MODE_PUT) begin
            slot = -1;
            if (lines_used < cap_limit())
                for (int j = 0; j < lkvc_pkg::ENTRIES; j++)
                    if (slot < 0 && !line_valid[j]) slot = j;
            if (slot < 0) begin
                // full, or capacity lowered under the fill level: drop the oldest
                for (int j = 0; j < lkvc_pkg::ENTRIES; j++)
                    if (line_valid[j] && (slot < 0 || line_rank[j] > line_rank[slot])) slot = j;
                if (slot >= 0) begin
                    ans.evicted     = 1'b1;
                    ans.evicted_key = line_key[slot];
                    line_valid[slot] = 1'b0;
                    lines_used--;
                end
            end
            if (slot >= 0) begin
                for (int j = 0; j < lkvc_pkg::ENTRIES; j++)
                    if (line_valid[j]) line_rank[j]++;
                line_key[slot]   = key;
                line_value[slot] = value;
                line_valid[slot] = 1'b1;
                line_rank[slot]  = 0;
                lines_used++;
            end
        end
        return ans;
    endfunction

    task automatic queue_op(input logic mode, input logic [lkvc_pkg::KEY_W-1:0] key,
                            input logic [lkvc_pkg::VAL_W-1:0] value);
        t_cache_op op;
        op.is_cap_write = 1'b0;
        op.mode  = mode;
        op.key   = key;
        op.value = value;
        op.cap   = '0;
        op_queue.push_back(op);
    endtask

    task automatic queue_cap(input logic [lkvc_pkg::CAP_W-1:0] cap);
        t_cache_op op;
        op.is_cap_write = 1'b1;
        op.mode  = lkvc_pkg::MODE_GET;
        op.key   = '0;
        op.value = '0;
        op.cap   = cap;
        op_queue.push_back(op);
    endtask

    // ---------------------------------------------------------------
    // driver: presents one beat at a time, idles a random gap, which may be zero, between beats
    // ---------------------------------------------------------------
    int hold_off;
    bit gap_any_phase;  // count idle cycles while busy too, so start rises mid-scan
    bit no_idle;        // stretch of back-to-back beats

    task automatic draw_idle();
        if ($urandom_range(0, 39) == 0) no_idle = !no_idle;
        hold_off      = no_idle ? 0 : $urandom_range(0, 8);
        gap_any_phase = $urandom_range(0, 1);
    endtask

    always @(posedge i_clk) begin
        bit taken;
        t_cache_op nxt;
        if (!i_rst_n) begin
            start    <= 1'b0;
            i_cfg_we <= 1'b0;
            hold_off = 0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                beats_sent++;
                draw_idle();
            end else if (i_cfg_we) begin
                draw_idle();
            end else if (!start && hold_off > 0 && (gap_any_phase || !busy)) begin
                hold_off--;
            end

            if (i_cfg_we) i_cfg_we <= 1'b0;

            if (start && !taken) begin
                // beat still waiting for busy to drop, keep it on the ports
            end else if (hold_off == 0 && op_queue.size() > 0) begin
                nxt = op_queue[0];
                if (nxt.is_cap_write) begin
                    start <= 1'b0;
                    // capacity only changes with the block idle and every answer back
                    if (!taken && !i_cfg_we && !busy && beats_sent == results_seen) begin
                        i_cfg_we    <= 1'b1;
                        i_cfg_wdata <= nxt.cap;
                        void'(op_queue.pop_front());
                    end
                end else begin
                    start         <= 1'b1;
                    i_mode        <= nxt.mode;
                    i_lookup_key  <= nxt.key;
                    i_store_value <= nxt.value;
                    void'(op_queue.pop_front());
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: check answers first, then predict the beat taken at this edge
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin
        t_lookup_answer want;
        t_lookup_answer got;
        if (!i_rst_n) begin
            for (int j = 0; j < lkvc_pkg::ENTRIES; j++) begin
                line_valid[j] = 1'b0;
                line_rank[j]  = 0;
                line_key[j]   = '0;
                line_value[j] = '0;
            end
            lines_used = 0;
            cap_reg    = lkvc_pkg::CAP_RESET;
        end else begin
            if (o_valid) begin
                results_seen <= results_seen + 1;
                got.found       = o_found;
                got.read_data   = o_read_data;
                got.evicted     = o_evicted;
                got.evicted_key = o_evicted_key;
                if (pending_lookups.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected answer: %0b %08h %0b %04h",
                                 $realtime, got.found, got.read_data, got.evicted,
                                 got.evicted_key);
                end else begin
                    want = pending_lookups.pop_front();
                    if (got.found !== want.found || got.read_data !== want.read_data ||
                        got.evicted !== want.evicted || got.evicted_key !== want.evicted_key) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("[%0t] exp %0b %08h %0b %04h got %0b %08h %0b %04h",
                                     $realtime, want.found, want.read_data, want.evicted,
                                     want.evicted_key, got.found, got.read_data, got.evicted,
                                     got.evicted_key);
                    end
                end
            end
            if (i_cfg_we) cap_reg = i_cfg_wdata;
            if (start && !busy)
                pending_lookups.push_back(cache_access(i_mode, i_lookup_key, i_store_value));
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin
        logic [lkvc_pkg::CAP_W-1:0] phase_cap [PHASES];
        logic [lkvc_pkg::KEY_W-1:0] key_pool  [32];
        int span;
        int n_ops;
        logic [lkvc_pkg::KEY_W-1:0] k;

        beats_sent    = 0;
        results_seen  = 0;
        mismatches    = 0;
        cycle_count   = 0;
        hold_off      = 0;
        gap_any_phase = 1'b0;
        no_idle       = 1'b0;

        // directed: empty store, key and value extremes, update, fill, eviction
        queue_op(lkvc_pkg::MODE_GET, 16'h0000, 32'h0000_0000);  // miss on empty store
        queue_op(lkvc_pkg::MODE_PUT, 16'h0000, 32'h8000_0000);
        queue_op(lkvc_pkg::MODE_PUT, 16'hFFFF, 32'h7FFF_FFFF);
        queue_op(lkvc_pkg::MODE_GET, 16'hFFFF, 32'hA5A5_5A5A);  // hit, value on get ignored
        queue_op(lkvc_pkg::MODE_GET, 16'h0000, 32'hFFFF_FFFF);  // hit, 0000 now most recent
        queue_op(lkvc_pkg::MODE_PUT, 16'h0000, 32'hFFFF_FFFF);  // update of present key
        queue_op(lkvc_pkg::MODE_GET, 16'h0000, 32'h0000_0000);
        queue_op(lkvc_pkg::MODE_GET, 16'h1234, 32'h5555_AAAA);  // miss on absent key
        for (int i = 1; i <= 14; i++)                           // fill to sixteen
            queue_op(lkvc_pkg::MODE_PUT, lkvc_pkg::KEY_W'(i * 16'h1111 + i), $urandom);
        queue_op(lkvc_pkg::MODE_PUT, 16'hBEEF, 32'h0000_0001);  // full: oldest (FFFF) goes
        queue_op(lkvc_pkg::MODE_GET, 16'hFFFF, 32'h0000_0000);  // evicted key misses
        queue_op(lkvc_pkg::MODE_PUT, 16'h0000, 32'h0000_0002);  // present key, no eviction

        // capacity per phase: under the fill level, zero, one, saturated, random
        phase_cap[0]  = 5'd3;
        phase_cap[1]  = 5'd1;
        phase_cap[2]  = 5'd0;
        phase_cap[3]  = 5'd31;
        phase_cap[4]  = 5'd16;
        phase_cap[5]  = 5'd2;
        phase_cap[6]  = 5'd9;
        phase_cap[7]  = 5'd5;
        phase_cap[8]  = 5'd17;
        phase_cap[9]  = 5'd12;
        phase_cap[10] = lkvc_pkg::CAP_W'($urandom_range(0, 31));
        phase_cap[11] = lkvc_pkg::CAP_W'($urandom_range(0, 31));

        for (int p = 0; p < PHASES; p++) begin
            queue_cap(phase_cap[p]);
            for (int i = 0; i < 32; i++)
                key_pool[i] = lkvc_pkg::KEY_W'($urandom_range(0, 65535));
            key_pool[0] = 16'h0000;
            key_pool[1] = 16'hFFFF;
            // working set a little wider than the capacity: hits, misses and evictions
            span  = ((phase_cap[p] > 5'd16) ? 16 : int'(phase_cap[p])) + 3;
            n_ops = $urandom_range(130, 170);
            for (int i = 0; i < n_ops; i++) begin
                if ($urandom_range(0, 9) == 0) k = lkvc_pkg::KEY_W'($urandom_range(0, 65535));
                else k = key_pool[$urandom_range(0, span - 1)];
                queue_op($urandom_range(0, 1) ? lkvc_pkg::MODE_PUT : lkvc_pkg::MODE_GET,
                         k, $urandom);
            end
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // drain: every op issued and every answer back
        do @(negedge i_clk);
        while (!(op_queue.size() == 0 && !start && !i_cfg_we && beats_sent == results_seen));
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (pending_lookups.size() != 0) mismatches += pending_lookups.size();
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

`default_nettype wire
